FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the host blocklist match unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while the async reset is asserted.
`define HBM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property, checked through reset as well.
`define HBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define HBM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/hbm_pkg.sv
// Shared constants, types and functions of the host blocklist match unit.
package hbm_pkg;
	localparam int ENTRIES    = 16;
	localparam int IDX_W      = 4;
	localparam int DEPTH      = 256;
	localparam int ADDR_W     = 8;
	localparam int PREFIX_LEN = 6;
	localparam int OFF_W      = 9;
	localparam int EIU_W      = 5;
	localparam int IN_W       = 32;
	localparam int OUT_W      = 16;

	localparam logic [OFF_W-1:0] OFF_MAX   = 9'd511;
	localparam logic [OFF_W-1:0] DOM_LIMIT = 9'd255;
	localparam logic [7:0]       CHAR_CR   = 8'h0d;
	localparam logic [7:0]       CHAR_LF   = 8'h0a;

	localparam logic [1:0] CMD_PAYLOAD = 2'd0;
	localparam logic [1:0] CMD_WR_BYTE = 2'd1;
	localparam logic [1:0] CMD_SET_LEN = 2'd2;

	typedef struct packed {
		logic accept;   // request taken this cycle
		logic capture;  // payload request taken, latch it and read the table
		logic step;     // apply the latched payload byte
	} hbm_cmd_t;

	typedef struct packed {
		logic payload;    // request on the input is a payload byte
		logic has_result; // latched byte closes a host line
	} hbm_status_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h68; // h
			3'd1: c = 8'h6f; // o
			3'd2: c = 8'h73; // s
			3'd3: c = 8'h74; // t
			3'd4: c = 8'h3a; // :
			3'd5: c = 8'h20; // space
			default: c = 8'h00;
		endcase
		return c;
	endfunction
endpackage

FILE: rtl/core/hbm_ctrl.sv
// Controller FSM: request handshake, step sequencing and result valid.
`include "assert_macros.svh"
module hbm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  hbm_pkg::hbm_status_t stat,
	output hbm_pkg::hbm_cmd_t    cmd
);
	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign out_free    = !out_valid_q || out_ready;
	assign cmd.accept  = in_valid && in_ready;
	assign cmd.capture = cmd.accept && stat.payload;
	assign cmd.step    = (state_q == S_EXEC) && (!stat.has_result || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step && stat.has_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.step) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HBM_ASSERT(a_out_hold, clk, arst_n, out_valid_q && !out_ready |=> out_valid_q, "result dropped while stalled")
	`HBM_ASSERT(a_exec_entry, clk, arst_n, (state_q == S_EXEC) && ($past(state_q) == S_IDLE) |-> $past(cmd.capture), "exec without payload request")
	`HBM_ASSERT(a_no_overwrite, clk, arst_n, !(cmd.step && stat.has_result && out_valid_q && !out_ready), "result overwrites a pending one")
endmodule

FILE: rtl/core/hbm_datapath.sv
// Datapath: domain table banks, line state, per-entry compare and result register.
module hbm_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [hbm_pkg::EIU_W-1:0]   cfg_wdata,
	input  logic [hbm_pkg::IN_W-1:0]    in_data,
	input  logic                        in_last,
	input  hbm_pkg::hbm_cmd_t           cmd,
	output hbm_pkg::hbm_status_t        stat,
	output logic [hbm_pkg::OUT_W-1:0]   out_data
);
	localparam int N = hbm_pkg::ENTRIES;

	logic [1:0]                    in_cmd;
	logic [7:0]                    in_byte;
	logic [hbm_pkg::IDX_W-1:0]     in_idx;
	logic [hbm_pkg::ADDR_W-1:0]    in_pos;
	logic [7:0]                    in_len;

	assign in_cmd  = in_data[1:0];
	assign in_byte = in_data[9:2];
	assign in_idx  = in_data[13:10];
	assign in_pos  = in_data[21:14];
	assign in_len  = in_data[29:22];

	logic [hbm_pkg::EIU_W-1:0] eiu_q;
	logic [7:0]                len_q [N];
	logic [hbm_pkg::OFF_W-1:0] off_q;
	logic                      pg_q, pcr_q, ovf_q;
	logic [N-1:0]              alive_q;
	logic [7:0]                byte_s1;
	logic                      eop_s1;
	logic [7:0]                rd_s1 [N];
	logic [hbm_pkg::OUT_W-1:0] out_q;

	// Read address: the byte lands one place further when a lone CR goes first.
	logic [hbm_pkg::OFF_W-1:0]  off_eff;
	logic [hbm_pkg::ADDR_W-1:0] raddr;
	assign off_eff = off_q + hbm_pkg::OFF_W'(pcr_q);
	assign raddr   = hbm_pkg::ADDR_W'(off_eff - hbm_pkg::OFF_W'(hbm_pkg::PREFIX_LEN));

	for (genvar g = 0; g < N; g++) begin : g_bank
		logic [7:0] mem [hbm_pkg::DEPTH];
		always_ff @(posedge clk) begin
			if (cmd.accept && in_cmd == hbm_pkg::CMD_WR_BYTE
					&& in_idx == hbm_pkg::IDX_W'(g)) begin
				mem[in_pos] <= in_byte;
			end
			if (cmd.capture) begin
				rd_s1[g] <= mem[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_s1 <= in_byte;
			eop_s1  <= in_last;
		end
	end

	// Next line state
	logic [hbm_pkg::OFF_W-1:0] o1, p1, hlen;
	logic                      pg1, ovf1, fin, hit;
	logic [N-1:0]              alive1;
	logic [hbm_pkg::IDX_W-1:0] hidx;

	always_comb begin
		o1     = off_q;
		pg1    = pg_q;
		ovf1   = ovf_q;
		alive1 = alive_q;
		if (pcr_q) begin
			if (o1 < hbm_pkg::OFF_W'(hbm_pkg::PREFIX_LEN)) pg1 = 1'b0;
			else ovf1 = 1'b1;
			if (o1 != hbm_pkg::OFF_MAX) o1 = o1 + hbm_pkg::OFF_W'(1);
		end
		p1 = o1 - hbm_pkg::OFF_W'(hbm_pkg::PREFIX_LEN);
		if (byte_s1 != hbm_pkg::CHAR_CR) begin
			if (o1 < hbm_pkg::OFF_W'(hbm_pkg::PREFIX_LEN)) begin
				if (byte_s1 != hbm_pkg::prefix_char(o1[2:0])) pg1 = 1'b0;
			end else if (p1 >= hbm_pkg::DOM_LIMIT) begin
				ovf1 = 1'b1;
			end else begin
				for (int i = 0; i < N; i++) begin
					if (p1 >= {1'b0, len_q[i]} || rd_s1[i] != byte_s1) alive1[i] = 1'b0;
				end
			end
			if (o1 != hbm_pkg::OFF_MAX) o1 = o1 + hbm_pkg::OFF_W'(1);
		end
	end

	// Line end and lowest matching entry
	always_comb begin
		fin  = pcr_q && (byte_s1 == hbm_pkg::CHAR_LF);
		hlen = off_q - hbm_pkg::OFF_W'(hbm_pkg::PREFIX_LEN);
		hit  = 1'b0;
		hidx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (hbm_pkg::EIU_W'(i) < eiu_q && alive_q[i] && !ovf_q
					&& {1'b0, len_q[i]} == hlen) begin
				hit  = 1'b1;
				hidx = hbm_pkg::IDX_W'(i);
			end
		end
	end

	assign stat.payload    = (in_cmd == hbm_pkg::CMD_PAYLOAD);
	assign stat.has_result = fin && pg_q && (off_q >= hbm_pkg::OFF_W'(hbm_pkg::PREFIX_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eiu_q   <= '0;
			off_q   <= '0;
			pg_q    <= 1'b1;
			pcr_q   <= 1'b0;
			ovf_q   <= 1'b0;
			alive_q <= '1;
			for (int i = 0; i < N; i++) len_q[i] <= '0;
		end else begin
			if (cfg_we) eiu_q <= cfg_wdata;
			if (cmd.accept && in_cmd == hbm_pkg::CMD_SET_LEN) len_q[in_idx] <= in_len;
			if (cmd.step) begin
				if (fin || eop_s1) begin
					off_q   <= '0;
					pg_q    <= 1'b1;
					pcr_q   <= 1'b0;
					ovf_q   <= 1'b0;
					alive_q <= '1;
				end else begin
					off_q   <= o1;
					pg_q    <= pg1;
					pcr_q   <= (byte_s1 == hbm_pkg::CHAR_CR);
					ovf_q   <= ovf1;
					alive_q <= alive1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && stat.has_result) begin
			out_q <= {2'b00, ovf_q,
				(hlen > hbm_pkg::DOM_LIMIT) ? 8'hff : hlen[7:0], hidx, hit};
		end
	end

	assign out_data = out_q;
endmodule

FILE: rtl/core/http_host_blocklist_match_unit.sv
// Top level of the HTTP host header blocklist match unit.
//
//  channel | dir | handshake         | contents
//  s_*     | in  | s_tvalid/s_tready | one request: payload byte or table command
//  m_*     | out | m_tvalid/m_tready | one result per finished host line
//  cfg_*   | in  | cfg_we            | entries_in_use, 5 bits
//
// Steps: a table command is applied as it is accepted; a payload byte first
//   reads all 16 table banks at the line offset, then updates line state,
//   which waits while a finished result still blocks the output register.
// Reset: arst_n clears line state, entry lengths and entries_in_use; table
//   bytes are undefined until written. No clearing pass.
// Stalls: a finished result waits in the output register while requests
//   keep flowing; a second host-line result stalls the input until the first is taken.
`include "assert_macros.svh"
module http_host_blocklist_match_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hbm_pkg::EIU_W-1:0]       cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [1:0] command, [9:2] data_byte, [13:10] entry_index,
	// [21:14] byte_position, [29:22] entry_length, [31:30] zero
	input  logic [hbm_pkg::IN_W-1:0]        s_tdata,
	input  logic                            s_tlast, // end_of_packet
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] matched, [4:1] match_entry, [12:5] host_length,
	// [13] host_too_long, [15:14] zero
	output logic [hbm_pkg::OUT_W-1:0]       m_tdata
);
	hbm_pkg::hbm_cmd_t    cmd;
	hbm_pkg::hbm_status_t stat;

	hbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hbm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

	`HBM_ASSERT(a_flags_clean, clk, arst_n, m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0, "match_entry set without match")
	`HBM_ASSERT(a_long_nomatch, clk, arst_n, m_tvalid && m_tdata[13] |-> !m_tdata[0], "flagged domain matched")
	`HBM_ASSERT(a_pad_zero, clk, arst_n, m_tvalid |-> m_tdata[15:14] == 2'd0, "result padding not zero")
endmodule
